>>> rtl/matrix_inverse_3x3_defines.svh
// ----------------------------------------------------------------------------
// matrix inverse assertion macros
// assertion helpers for matrix_inverse_3x3, empty for synthesis
// ----------------------------------------------------------------------------
`ifndef MATRIX_INVERSE_3X3_DEFINES_SVH
`define MATRIX_INVERSE_3X3_DEFINES_SVH
`ifndef SYNTHESIS
`define MI_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define MI_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define MI_ASSERT_IMP(label, clk, rst, ante, cons)
`define MI_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

>>> rtl/minv_pkg.sv
// ----------------------------------------------------------------------------
// minv_pkg
// widths and shared types for the 3x3 matrix inverse pipeline
// ----------------------------------------------------------------------------
package minv_pkg;
  localparam int ElemW  = 16;
  localparam int MinorW = 33;
  localparam int DetW   = 50;
  localparam int NumW   = MinorW + 28;
  localparam int OutW   = 32;
  // four quotient bits per divider stage
  localparam int DefDivStages = 16;

  typedef logic signed [ElemW-1:0]  elem_t;
  typedef logic signed [MinorW-1:0] minor_t;
  typedef logic signed [DetW-1:0]   det_t;
  typedef logic signed [OutW-1:0]   out_t;
endpackage

>>> rtl/minv_divider.sv
// ----------------------------------------------------------------------------
// minv_divider
// pipelined restoring divider for (minor * 2^28) / det, truncating, saturating
// ----------------------------------------------------------------------------
module minv_divider import minv_pkg::*; #(
  parameter int Stages = DefDivStages
) (
  input  logic   clk,
  input  logic   en,
  input  minor_t minor,
  input  det_t   det,
  output out_t   q
);
  localparam int Bits = NumW;
  localparam int Per  = (Bits + Stages - 1) / Stages;
  localparam int DenW = DetW;

  // per-stage registered state: magnitudes, partial remainder, quotient bits
  logic [Bits-1:0] num_s [Stages+1];
  logic [DenW-1:0] den_s [Stages+1];
  logic [DenW:0]   rem_s [Stages+1];
  logic [Bits-1:0] quo_s [Stages+1];
  logic            neg_s [Stages+1];

  logic [NumW-1:0] num_abs;
  logic [DenW-1:0] den_abs;

  always_comb begin
    logic signed [NumW-1:0] n;
    n = {minor, 28'd0};
    num_abs = n[NumW-1] ? NumW'(-n) : NumW'(n);
    den_abs = det[DetW-1] ? DenW'(-det) : DenW'(det);
  end

  assign num_s[0] = num_abs;
  assign den_s[0] = den_abs;
  assign rem_s[0] = '0;
  assign quo_s[0] = '0;
  assign neg_s[0] = minor[MinorW-1] ^ det[DetW-1];

  for (genvar s = 0; s < Stages; s++) begin : g_stage
    logic [Bits-1:0] num_n, quo_n;
    logic [DenW:0]   rem_n;
    always_comb begin
      logic [DenW+1:0] t;
      num_n = num_s[s];
      quo_n = quo_s[s];
      rem_n = rem_s[s];
      for (int b = 0; b < Per; b++) begin
        if (s * Per + b < Bits) begin
          t = {rem_n, num_n[Bits-1]};
          num_n = {num_n[Bits-2:0], 1'b0};
          if (t >= {2'b00, den_s[s]}) begin
            t = t - {2'b00, den_s[s]};
            quo_n = {quo_n[Bits-2:0], 1'b1};
          end else begin
            quo_n = {quo_n[Bits-2:0], 1'b0};
          end
          rem_n = t[DenW:0];
        end
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        num_s[s+1] <= num_n;
        den_s[s+1] <= den_s[s];
        rem_s[s+1] <= rem_n;
        quo_s[s+1] <= quo_n;
        neg_s[s+1] <= neg_s[s];
      end
    end
  end

  always_comb begin
    logic [Bits-1:0] mag;
    mag = quo_s[Stages];
    if (neg_s[Stages]) begin
      if (mag > Bits'(64'h8000_0000)) q = 32'sh8000_0000;
      else q = OutW'(-mag);
    end else begin
      if (mag > Bits'(64'h7fff_ffff)) q = 32'sh7fff_ffff;
      else q = OutW'(mag);
    end
  end
endmodule

>>> rtl/minv_cofactor.sv
// ----------------------------------------------------------------------------
// minv_cofactor
// registered signed 2x2 minor: sign * (a*d - b*c), products then difference
// ----------------------------------------------------------------------------
module minv_cofactor import minv_pkg::*; #(
  parameter bit Negate = 1'b0
) (
  input  logic   clk,
  input  logic   en,
  input  elem_t  a,
  input  elem_t  b,
  input  elem_t  c,
  input  elem_t  d,
  output minor_t minor
);
  logic signed [2*ElemW-1:0] p0, p1;
  always_ff @(posedge clk) begin
    if (en) begin
      p0 <= a * d;
      p1 <= b * c;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      if (Negate) minor <= MinorW'(p1) - MinorW'(p0);
      else        minor <= MinorW'(p0) - MinorW'(p1);
    end
  end
endmodule

>>> rtl/matrix_inverse_3x3.sv
// ----------------------------------------------------------------------------
// matrix_inverse_3x3
// fully pipelined 3x3 inverse by the adjugate, Q4.12 in, Q16.16 out
// ----------------------------------------------------------------------------
// one matrix a cycle enters, one inverse a cycle leaves, while not stalled;
// the registers in order are the cofactor products and differences, the
// determinant products and sum, the stages of the nine parallel dividers
// and the output register. the whole pipe advances when the output register
// is empty or being taken, so a stall holds every stage and loses nothing.
// a zero determinant gives all-zero elements and singular set.
module matrix_inverse_3x3 import minv_pkg::*; #(
  parameter int DivStages = DefDivStages
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  elem_t m00, input elem_t m01, input elem_t m02,
  input  elem_t m10, input elem_t m11, input elem_t m12,
  input  elem_t m20, input elem_t m21, input elem_t m22,
  output logic out_valid,
  input  logic out_ready,
  output out_t inv00, output out_t inv01, output out_t inv02,
  output out_t inv10, output out_t inv11, output out_t inv12,
  output out_t inv20, output out_t inv21, output out_t inv22,
  output logic singular
);
`include "matrix_inverse_3x3_defines.svh"
  localparam int Depth = 4 + DivStages;

  logic en;
  logic [Depth:0] vld;

  // pipe moves when the output register is free or being emptied
  assign en       = !out_valid || out_ready;
  assign in_ready = en;
  assign vld[0]   = in_valid;

  always_ff @(posedge clk) begin
    if (rst) vld[Depth:1] <= '0;
    else if (en) vld[Depth:1] <= vld[Depth-1:0];
  end

  // first row elements travel alongside the cofactors for the determinant
  elem_t r00, r01, r02, s00, s01, s02;
  always_ff @(posedge clk) begin
    if (en) begin
      r00 <= m00; r01 <= m01; r02 <= m02;
      s00 <= r00; s01 <= r01; s02 <= r02;
    end
  end

  // adjugate entries aRC: cofactor of element (C,R)
  minor_t a00, a01, a02, a10, a11, a12, a20, a21, a22;
  minv_cofactor #(1'b0) u_c00 (clk, en, m11, m12, m21, m22, a00);
  minv_cofactor #(1'b1) u_c10 (clk, en, m10, m12, m20, m22, a10);
  minv_cofactor #(1'b0) u_c20 (clk, en, m10, m11, m20, m21, a20);
  minv_cofactor #(1'b1) u_c01 (clk, en, m01, m02, m21, m22, a01);
  minv_cofactor #(1'b0) u_c11 (clk, en, m00, m02, m20, m22, a11);
  minv_cofactor #(1'b1) u_c21 (clk, en, m00, m01, m20, m21, a21);
  minv_cofactor #(1'b0) u_c02 (clk, en, m01, m02, m11, m12, a02);
  minv_cofactor #(1'b1) u_c12 (clk, en, m00, m02, m10, m12, a12);
  minv_cofactor #(1'b0) u_c22 (clk, en, m00, m01, m10, m11, a22);

  // determinant: three products registered, then summed
  det_t dp0, dp1, dp2, det;
  minor_t b [9];
  minor_t bb [9];
  always_ff @(posedge clk) begin
    if (en) begin
      dp0 <= DetW'(s00 * a00);
      dp1 <= DetW'(s01 * a10);
      dp2 <= DetW'(s02 * a20);
      det <= dp0 + dp1 + dp2;
      b  <= '{a00, a01, a02, a10, a11, a12, a20, a21, a22};
      bb <= b;
    end
  end

  // determinant zero flag follows the divider pipe
  logic [DivStages:0] zero_s;
  assign zero_s[0] = (det == '0);
  always_ff @(posedge clk) begin
    if (en) zero_s[DivStages:1] <= zero_s[DivStages-1:0];
  end

  out_t q [9];
  for (genvar k = 0; k < 9; k++) begin : g_div
    minv_divider #(DivStages) u_div (
      .clk(clk), .en(en), .minor(bb[k]), .det(det), .q(q[k])
    );
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= vld[Depth];
  end
  always_ff @(posedge clk) begin
    if (en) begin
      singular <= zero_s[DivStages];
      inv00 <= zero_s[DivStages] ? '0 : q[0];
      inv01 <= zero_s[DivStages] ? '0 : q[1];
      inv02 <= zero_s[DivStages] ? '0 : q[2];
      inv10 <= zero_s[DivStages] ? '0 : q[3];
      inv11 <= zero_s[DivStages] ? '0 : q[4];
      inv12 <= zero_s[DivStages] ? '0 : q[5];
      inv20 <= zero_s[DivStages] ? '0 : q[6];
      inv21 <= zero_s[DivStages] ? '0 : q[7];
      inv22 <= zero_s[DivStages] ? '0 : q[8];
    end
  end

  `MI_ASSERT_IMP(a_ready_free, clk, rst, !out_valid, in_ready)
  `MI_ASSERT_NEXT(a_hold_stall, clk, rst, out_valid && !out_ready, out_valid && $stable(inv00))
  `MI_ASSERT_IMP(a_sing_zero, clk, rst, out_valid && singular, inv11 == '0 && inv22 == '0)
endmodule
